FILE: src/pnguf_pkg.sv
// ----------------------------------------------------------------------------
// pnguf_pkg
// Shared constants for the PNG scanline unfilter block: row store size,
// field widths, filter type codes and configuration register indexes.
// ----------------------------------------------------------------------------
package pnguf_pkg;

  // Default row store depth in bytes.
  localparam int MAX_ROW_BYTES_DEF = 8192;

  // Field widths.
  localparam int BYTE_W       = 8;
  localparam int ROW_PIXELS_W = 14;
  localparam int CFG_DATA_W   = 14;
  localparam int CFG_INDEX_W  = 1;

  // Filter type codes of filter method 0.
  localparam logic [BYTE_W-1:0] FILT_NONE  = 8'd0;
  localparam logic [BYTE_W-1:0] FILT_SUB   = 8'd1;
  localparam logic [BYTE_W-1:0] FILT_UP    = 8'd2;
  localparam logic [BYTE_W-1:0] FILT_AVG   = 8'd3;
  localparam logic [BYTE_W-1:0] FILT_PAETH = 8'd4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_PIXELS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MODE = 1'd1;

endpackage

FILE: src/pnguf_ram.sv
// ----------------------------------------------------------------------------
// pnguf_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pnguf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/pnguf_recon.sv
// ----------------------------------------------------------------------------
// pnguf_recon
// Byte reconstruction for one filtered sample: None, Sub, Up, Average and
// Paeth rules, with a flag that tells whether the filter type is known.
// ----------------------------------------------------------------------------
module pnguf_recon (
  input  logic [pnguf_pkg::BYTE_W-1:0] raw,
  input  logic [pnguf_pkg::BYTE_W-1:0] code,
  input  logic [pnguf_pkg::BYTE_W-1:0] a,
  input  logic [pnguf_pkg::BYTE_W-1:0] b,
  input  logic [pnguf_pkg::BYTE_W-1:0] c,
  output logic [pnguf_pkg::BYTE_W-1:0] val,
  output logic                         known
);
  import pnguf_pkg::*;

  // Paeth predictor: the neighbor closest to a + b - c, ties to a, then b.
  function automatic logic [BYTE_W-1:0] paeth_pick(
    input logic [BYTE_W-1:0] pa_in,
    input logic [BYTE_W-1:0] pb_in,
    input logic [BYTE_W-1:0] pc_in
  );
    logic signed [BYTE_W+2:0] sa;
    logic signed [BYTE_W+2:0] sb;
    logic signed [BYTE_W+2:0] sc;
    logic signed [BYTE_W+2:0] da;
    logic signed [BYTE_W+2:0] db;
    logic signed [BYTE_W+2:0] dc;
    logic [BYTE_W+2:0]        pa;
    logic [BYTE_W+2:0]        pb;
    logic [BYTE_W+2:0]        pc;
    logic [BYTE_W-1:0]        pick;
    sa = $signed({3'b000, pa_in});
    sb = $signed({3'b000, pb_in});
    sc = $signed({3'b000, pc_in});
    da = sb - sc;
    db = sa - sc;
    dc = sa + sb - (sc <<< 1);
    pa = (da < 0) ? $unsigned(-da) : $unsigned(da);
    pb = (db < 0) ? $unsigned(-db) : $unsigned(db);
    pc = (dc < 0) ? $unsigned(-dc) : $unsigned(dc);
    if (pa <= pb && pa <= pc) begin
      pick = pa_in;
    end else if (pb <= pc) begin
      pick = pb_in;
    end else begin
      pick = pc_in;
    end
    return pick;
  endfunction

  logic [BYTE_W:0] avg_sum;

  assign avg_sum = {1'b0, a} + {1'b0, b};

  // Apply the rule of the row's filter type; sums wrap modulo 256.
  always_comb begin
    known = 1'b1;
    case (code)
      FILT_NONE:  val = raw;
      FILT_SUB:   val = raw + a;
      FILT_UP:    val = raw + b;
      FILT_AVG:   val = raw + avg_sum[BYTE_W:1];
      FILT_PAETH: val = raw + paeth_pick(a, b, c);
      default: begin
        val   = raw;
        known = 1'b0;
      end
    endcase
  end

endmodule

FILE: src/png_scanline_unfilter_core.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter_core
// PNG scanline reconstruction for 8-bit gray or RGB rows, one byte per item.
// Path: an accepted sample is registered into the second stage, where it is
// rebuilt, then written into the output queue, from which it is shown.
// Throughput: one item per cycle while the output queue has room, set by the
// single read port of the prior-row RAM: read at accept, written back next cycle.
// Reset: synchronous; the row counter expects a filter byte, the first row's
// prior reads as zeros, and the prior-row RAM is not cleared.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_core #(
  parameter int MAX_ROW_BYTES = pnguf_pkg::MAX_ROW_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [pnguf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pnguf_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Input stream.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] raw_byte
  input  logic                              s_tuser,   // [0] image_start
  // Output stream.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [7:0]                        m_tdata,   // [7:0] pixel_byte
  output logic                              m_tlast    // row_last
);
  import pnguf_pkg::*;

  localparam int AW         = $clog2(MAX_ROW_BYTES);
  localparam int CW         = $clog2(MAX_ROW_BYTES + 1);
  localparam int PW         = (CW > ROW_PIXELS_W) ? CW : ROW_PIXELS_W;
  localparam int MAX_PX_RGB = MAX_ROW_BYTES / 3;
  localparam int FIFO_DEPTH = 3;
  localparam int FPW        = $clog2(FIFO_DEPTH);
  localparam int FCW        = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } out_item_t;

  // Configuration registers.
  logic [ROW_PIXELS_W-1:0] row_pixels;
  logic                    color_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pixels <= ROW_PIXELS_W'(1);
      color_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_PIXELS: row_pixels <= cfg_data[ROW_PIXELS_W-1:0];
        REG_COLOR_MODE: color_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Row length in bytes: width (zero taken as one) capped to the row store.
  logic [PW-1:0]   px;
  logic [PW-1:0]   px_cap;
  logic [PW-1:0]   max_px;
  logic [PW+1:0]   len_full;
  logic [CW-1:0]   row_len;

  always_comb begin
    px       = (row_pixels == '0) ? PW'(1) : PW'(row_pixels);
    max_px   = color_mode ? PW'(MAX_PX_RGB) : PW'(MAX_ROW_BYTES);
    px_cap   = (px > max_px) ? max_px : px;
    len_full = color_mode ? ({2'b00, px_cap} + {1'b0, px_cap, 1'b0}) : {2'b00, px_cap};
    row_len  = len_full[CW-1:0];
  end

  // Front stage: row counter, filter register and first-row flag.
  logic [CW-1:0]     col_cnt;
  logic [BYTE_W-1:0] row_filter;
  logic              first_row;

  logic              accept;
  logic [CW-1:0]     cnt_eff;
  logic              first_eff;
  logic              in_filter;
  logic [CW-1:0]     pos_full;
  logic [AW-1:0]     pos0;
  logic [CW:0]       pos_inc;
  logic              in_last;

  assign accept    = s_tvalid & s_tready;
  assign cnt_eff   = s_tuser ? '0 : col_cnt;
  assign first_eff = s_tuser | first_row;
  assign in_filter = (cnt_eff == '0);
  assign pos_full  = cnt_eff - CW'(1);
  assign pos0      = pos_full[AW-1:0];
  assign pos_inc   = {1'b0, pos_full} + (CW+1)'(1);
  assign in_last   = (pos_inc >= {1'b0, row_len});

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt    <= '0;
      row_filter <= '0;
      first_row  <= 1'b1;
    end else if (accept) begin
      if (in_filter) begin
        row_filter <= s_tdata;
        col_cnt    <= CW'(1);
        first_row  <= first_eff;
      end else if (in_last) begin
        col_cnt   <= '0;
        first_row <= 1'b0;
      end else begin
        col_cnt <= cnt_eff + CW'(1);
      end
    end
  end

  // Second stage: carries the item while the prior-row byte is read.
  logic              s1_valid;
  logic              s1_filter_byte;
  logic [BYTE_W-1:0] s1_raw;
  logic [BYTE_W-1:0] s1_code;
  logic              s1_first;
  logic              s1_last;
  logic [AW-1:0]     s1_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_filter_byte <= in_filter;
      s1_raw         <= s_tdata;
      s1_code        <= row_filter;
      s1_first       <= first_eff;
      s1_last        <= in_last;
      s1_pos         <= pos0;
    end
  end

  // Prior-row store: read at accept, written back by the second stage.
  logic [BYTE_W-1:0] prior_rdata;
  logic              ram_we;
  logic [BYTE_W-1:0] val;

  assign ram_we = s1_valid & ~s1_filter_byte;

  pnguf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_ROW_BYTES)
  ) u_prior_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_pos),
    .wdata (val),
    .re    (accept),
    .raddr (pos0),
    .rdata (prior_rdata)
  );

  // Neighbor bytes: left is one pixel back, upper-left one pixel back above.
  logic [3*BYTE_W-1:0] left_bytes;
  logic [3*BYTE_W-1:0] upper_left_bytes;
  logic [BYTE_W-1:0]   nb_a;
  logic [BYTE_W-1:0]   nb_b;
  logic [BYTE_W-1:0]   nb_c;
  logic                known;

  assign nb_b = s1_first ? '0 : prior_rdata;
  assign nb_a = color_mode ? left_bytes[3*BYTE_W-1:2*BYTE_W] : left_bytes[BYTE_W-1:0];
  assign nb_c = color_mode ? upper_left_bytes[3*BYTE_W-1:2*BYTE_W]
                           : upper_left_bytes[BYTE_W-1:0];

  pnguf_recon u_recon (
    .raw   (s1_raw),
    .code  (s1_code),
    .a     (nb_a),
    .b     (nb_b),
    .c     (nb_c),
    .val   (val),
    .known (known)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      left_bytes       <= '0;
      upper_left_bytes <= '0;
    end else if (s1_valid) begin
      if (s1_filter_byte) begin
        left_bytes       <= '0;
        upper_left_bytes <= '0;
      end else begin
        left_bytes       <= {left_bytes[2*BYTE_W-1:0], val};
        upper_left_bytes <= {upper_left_bytes[2*BYTE_W-1:0], nb_b};
      end
    end
  end

  // Output queue: parts the rebuild stage from the output handshake.
  out_item_t      fifo_mem [FIFO_DEPTH];
  logic [FPW-1:0] wr_ptr;
  logic [FPW-1:0] rd_ptr;
  logic [FCW-1:0] fifo_cnt;
  logic           push;
  logic           pop;

  assign push     = ram_we & known;
  assign pop      = m_tvalid & m_tready;
  assign m_tvalid = (fifo_cnt != '0);
  assign m_tdata  = fifo_mem[rd_ptr].data;
  assign m_tlast  = fifo_mem[rd_ptr].last;
  assign s_tready = (({1'b0, fifo_cnt}) + (FCW+1)'(s1_valid)) < (FCW+1)'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FPW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + FPW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FPW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + FPW'(1);
      end
      fifo_cnt <= fifo_cnt + FCW'(push) - FCW'(pop);
    end
    if (push) begin
      fifo_mem[wr_ptr] <= '{data: val, last: s1_last};
    end
  end

  // Checks on the queue and on the store's read-after-write timing.
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_cnt <= FCW'(FIFO_DEPTH))
    else $error("output queue count beyond its depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> fifo_cnt < FCW'(FIFO_DEPTH))
    else $error("rebuilt item pushed into a full output queue");

  a_no_raw_hazard: assert property (@(posedge clk) disable iff (rst)
    ram_we && accept && !in_filter |-> pos0 != s1_pos)
    else $error("prior-row read collides with write-back of the same entry");

  a_credit: assert property (@(posedge clk) disable iff (rst)
    accept |=> fifo_cnt + FCW'(s1_valid) <= FCW'(FIFO_DEPTH))
    else $error("item accepted without room in the output queue");

endmodule
